// ----- design/etl_pkg.sv -----
// Package for the embedding tile locator: sizes, status codes and the
// controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps
package etl_pkg;

  localparam int MAX_DIMENSIONS = 4096;
  localparam int IDX_W  = $clog2(MAX_DIMENSIONS);
  localparam int CNT_W  = IDX_W + 1;
  localparam int LIDX_W = 12;   // logical_index / physical_index field width
  localparam int DC_W   = 13;   // dimension_count register width
  localparam int REP_W  = 2;
  localparam int BLK_W  = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 13;
  localparam int ST_W   = 3;
  localparam int VAL_W  = 9;    // values per tile, up to 288
  localparam int DIVD_W = 13;   // divider dividend width
  localparam int TBL_W  = LIDX_W + 1;  // written flag and physical index

  localparam logic [CFG_IDX_W-1:0] REG_REP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DC  = 2'd3;

  localparam logic [REP_W-1:0] REP_E1 = 2'd1;
  localparam logic [REP_W-1:0] REP_E2 = 2'd2;

  localparam logic OP_WRITE = 1'b0;

  typedef enum logic [ST_W-1:0] {
    ST_OK         = 3'd0,
    ST_NO_DIMS    = 3'd1,
    ST_BAD_PROF   = 3'd2,
    ST_INCOMPLETE = 3'd3,
    ST_NOT_BIJ    = 3'd4,
    ST_RANGE      = 3'd5
  } status_t;

  typedef struct packed {
    logic    clr_wr;
    logic    cnt_clr;
    logic    cnt_inc;
    logic    tbl_wr;
    logic    item_load;
    logic    tbl_rd_cnt;
    logic    tbl_rd_q;
    logic    seen_rd;
    logic    seen_clr;
    logic    seen_set;
    logic    bij_clr;
    logic    bij_set;
    logic    div_tc;
    logic    div_q;
    logic    cache_set;
    status_t cache_code;
    logic    tc_load;
    logic    out_load;
    logic    out_query;
    status_t out_status;
  } cmd_t;

  typedef struct packed {
    logic    cache_valid;
    status_t cached_status;
    status_t pre_status;
    logic    cnt_full;
    logic    cnt_at_end;
    logic    unwritten;
    logic    p_bad;
    logic    seen_hit;
    logic    bij_fail;
    logic    div_done;
    logic    div_busy;
    logic    out_free;
    logic    q_oor;
  } sts_t;

endpackage

// ----- design/etl_if.sv -----
// Handshake channel interfaces for the locator: request items in,
// result items out. Depends on etl_pkg.
`timescale 1ns / 1ps
interface etl_in_if import etl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [LIDX_W-1:0] logical_index;
  logic [LIDX_W-1:0] physical_index;
  modport source (output valid, output opcode, output logical_index,
                  output physical_index, input ready);
  modport sink   (input valid, input opcode, input logical_index,
                  input physical_index, output ready);
endinterface

interface etl_out_if import etl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ST_W-1:0]  status;
  logic [7:0]       tile_no;
  logic [7:0]       texel_no;
  logic             lane_index;
  logic [VAL_W-1:0] tile_count;
  modport source (output valid, output status, output tile_no,
                  output texel_no, output lane_index, output tile_count,
                  input ready);
  modport sink   (input valid, input status, input tile_no,
                  input texel_no, input lane_index, input tile_count,
                  output ready);
endinterface

// ----- design/etl_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module etl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

// ----- design/etl_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on etl_pkg.
`timescale 1ns / 1ps
module etl_div import etl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [VAL_W-1:0]  divisor,
  output logic [DIVD_W-1:0] quotient,
  output logic [VAL_W-1:0]  remainder,
  output logic              busy,
  output logic              done
);
  localparam int STEP_W = $clog2(DIVD_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIVD_W - 1);

  logic [DIVD_W-1:0] quo_r;
  logic [VAL_W-1:0]  rem_r, div_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r, done_r;
  logic [VAL_W:0]    trial, diff;
  logic              ge;

  assign trial = {rem_r, quo_r[DIVD_W-1]};
  assign ge    = trial >= {1'b0, div_r};
  assign diff  = trial - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIVD_W-2:0], ge};
      rem_r <= ge ? diff[VAL_W-1:0] : trial[VAL_W-1:0];
    end
  end

  assign quotient  = quo_r;
  assign remainder = rem_r;
  assign busy      = busy_r;
  assign done      = done_r;
endmodule

// ----- design/etl_dp.sv -----
// Datapath: config registers, permutation table and seen bitmap RAMs,
// walk counter, validation cache, divider and result register.
// Depends on etl_pkg, etl_ram, etl_div.
`timescale 1ns / 1ps
module etl_dp import etl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [LIDX_W-1:0]     in_logical,
  input  logic [LIDX_W-1:0]     in_physical,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [ST_W-1:0]       out_status,
  output logic [7:0]            out_tile,
  output logic [7:0]            out_texel,
  output logic                  out_lane,
  output logic [VAL_W-1:0]      out_tcount
);
  logic [REP_W-1:0] rep_r;
  logic [BLK_W-1:0] bw_r, bh_r;
  logic [DC_W-1:0]  dc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rep_r <= REP_E1;
      bw_r  <= BLK_W'(4);
      bh_r  <= BLK_W'(4);
      dc_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_REP: rep_r <= cfg_wdata[REP_W-1:0];
        REG_BW:  bw_r  <= cfg_wdata[BLK_W-1:0];
        REG_BH:  bh_r  <= cfg_wdata[BLK_W-1:0];
        REG_DC:  dc_r  <= cfg_wdata[DC_W-1:0];
        default: ;
      endcase
    end
  end

  // profile checks
  logic two_lanes, prof_ok;
  logic [VAL_W-1:0] area, values;
  assign two_lanes = (rep_r == REP_E2);
  assign prof_ok = ((rep_r == REP_E1) || two_lanes) &&
                   (bw_r >= BLK_W'(4)) && (bw_r <= BLK_W'(12)) &&
                   (bh_r >= BLK_W'(4)) && (bh_r <= BLK_W'(12));
  assign area   = VAL_W'(bw_r) * VAL_W'(bh_r);
  assign values = two_lanes ? {area[VAL_W-2:0], 1'b0} : area;

  status_t pre_st;
  always_comb begin
    if (dc_r == '0) begin
      pre_st = ST_NO_DIMS;
    end else if (!prof_ok) begin
      pre_st = ST_BAD_PROF;
    end else if (dc_r > DC_W'(MAX_DIMENSIONS)) begin
      pre_st = ST_INCOMPLETE;
    end else begin
      pre_st = ST_OK;
    end
  end
  assign sts.pre_status = pre_st;

  // walk counter
  logic [CNT_W-1:0] cnt_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.cnt_clr) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end
  assign sts.cnt_full   = (cnt_r[IDX_W-1:0] == '1);
  assign sts.cnt_at_end = ((DC_W+1)'(cnt_r) + 1'b1) == {1'b0, dc_r};

  // item latch
  logic [LIDX_W-1:0] q_logical_r;
  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      q_logical_r <= in_logical;
    end
  end
  assign sts.q_oor = {1'b0, q_logical_r} >= dc_r;

  // permutation table: written flag on top of the physical index
  logic             tbl_we, tbl_re;
  logic [IDX_W-1:0] tbl_waddr, tbl_raddr;
  logic [TBL_W-1:0] tbl_wdata, tbl_rdata;
  logic [LIDX_W-1:0] p;

  assign tbl_we    = cmd.clr_wr || cmd.tbl_wr;
  assign tbl_waddr = cmd.clr_wr ? cnt_r[IDX_W-1:0] : IDX_W'(in_logical);
  assign tbl_wdata = cmd.clr_wr ? '0 : {1'b1, in_physical};
  assign tbl_re    = cmd.tbl_rd_cnt || cmd.tbl_rd_q;
  assign tbl_raddr = cmd.tbl_rd_q ? IDX_W'(q_logical_r) : cnt_r[IDX_W-1:0];

  etl_ram #(.WIDTH(TBL_W), .DEPTH(MAX_DIMENSIONS)) u_tbl (
    .clk(clk), .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
    .re(tbl_re), .raddr(tbl_raddr), .rdata(tbl_rdata)
  );

  assign p             = tbl_rdata[LIDX_W-1:0];
  assign sts.unwritten = !tbl_rdata[TBL_W-1];
  assign sts.p_bad     = {1'b0, p} >= dc_r;

  // seen bitmap
  logic             seen_we, seen_rdata;
  logic [IDX_W-1:0] seen_waddr;
  assign seen_we    = cmd.seen_clr || cmd.seen_set;
  assign seen_waddr = cmd.seen_clr ? cnt_r[IDX_W-1:0] : IDX_W'(p);

  etl_ram #(.WIDTH(1), .DEPTH(MAX_DIMENSIONS)) u_seen (
    .clk(clk), .we(seen_we), .waddr(seen_waddr), .wdata(!cmd.seen_clr),
    .re(cmd.seen_rd), .raddr(IDX_W'(p)), .rdata(seen_rdata)
  );
  assign sts.seen_hit = seen_rdata;

  logic bij_r;
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.bij_clr) begin
      bij_r <= 1'b0;
    end else if (cmd.bij_set) begin
      bij_r <= 1'b1;
    end
  end
  assign sts.bij_fail = bij_r;

  // divider: tile count at validation, tile/offset per query
  logic [DIVD_W-1:0] div_dividend, quo;
  logic [VAL_W-1:0]  rem;
  assign div_dividend = cmd.div_tc ? DIVD_W'(dc_r + DC_W'(values) - 1'b1)
                                   : DIVD_W'(p);

  etl_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_tc || cmd.div_q),
    .dividend(div_dividend), .divisor(values), .quotient(quo),
    .remainder(rem), .busy(sts.div_busy), .done(sts.div_done)
  );

  // validation cache, dropped on any write item or config write
  logic             cache_valid_r;
  status_t          cache_st_r;
  logic [VAL_W-1:0] tc_r;
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we || cmd.tbl_wr) begin
      cache_valid_r <= 1'b0;
    end else if (cmd.cache_set) begin
      cache_valid_r <= 1'b1;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.cache_set) begin
      cache_st_r <= cmd.cache_code;
    end
    if (cmd.tc_load) begin
      tc_r <= quo[VAL_W-1:0];
    end
  end
  assign sts.cache_valid   = cache_valid_r;
  assign sts.cached_status = cache_st_r;

  // result register
  logic             ov_r, lane_r;
  logic [ST_W-1:0]  st_r;
  logic [7:0]       tile_r, texel_r;
  logic [VAL_W-1:0] otc_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.out_load) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      st_r <= cmd.out_status;
      if (cmd.out_query) begin
        tile_r  <= quo[7:0];
        texel_r <= two_lanes ? rem[8:1] : rem[7:0];
        lane_r  <= two_lanes & rem[0];
        otc_r   <= tc_r;
      end else begin
        tile_r  <= '0;
        texel_r <= '0;
        lane_r  <= 1'b0;
        otc_r   <= '0;
      end
    end
  end
  assign sts.out_free = !ov_r || out_ready;
  assign out_valid  = ov_r;
  assign out_status = st_r;
  assign out_tile   = tile_r;
  assign out_texel  = texel_r;
  assign out_lane   = lane_r;
  assign out_tcount = otc_r;
endmodule

// ----- design/etl_ctrl.sv -----
// Controller FSM: table clear after reset, layout validation walk,
// query sequencing and result hand-off. Depends on etl_pkg.
`timescale 1ns / 1ps
module etl_ctrl import etl_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_opcode,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);
  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_WR_FIN, S_V_PRE, S_V_SCLR, S_V_RD, S_V_T, S_V_S,
    S_V_END, S_V_TC, S_Q_CHK, S_Q_RD, S_Q_DIV, S_Q_FIN
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.cache_code = ST_OK;
    cmd.out_status = ST_OK;
    state_nxt = state_r;
    unique case (state_r)
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (sts.cnt_full) begin
          cmd.cnt_clr = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.item_load = 1'b1;
          if (in_opcode == OP_WRITE) begin
            cmd.tbl_wr = 1'b1;
            state_nxt = S_WR_FIN;
          end else if (sts.cache_valid) begin
            state_nxt = S_Q_CHK;
          end else begin
            state_nxt = S_V_PRE;
          end
        end
      end
      S_WR_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_V_PRE: begin
        cmd.cnt_clr = 1'b1;
        cmd.bij_clr = 1'b1;
        if (sts.pre_status != ST_OK) begin
          cmd.cache_set = 1'b1;
          cmd.cache_code = sts.pre_status;
          state_nxt = S_Q_CHK;
        end else begin
          state_nxt = S_V_SCLR;
        end
      end
      S_V_SCLR: begin
        cmd.seen_clr = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (sts.cnt_full) begin
          cmd.cnt_clr = 1'b1;
          state_nxt = S_V_RD;
        end
      end
      S_V_RD: begin
        cmd.tbl_rd_cnt = 1'b1;
        state_nxt = S_V_T;
      end
      S_V_T: begin
        if (sts.unwritten) begin
          cmd.cache_set = 1'b1;
          cmd.cache_code = ST_INCOMPLETE;
          state_nxt = S_Q_CHK;
        end else if (sts.p_bad) begin
          cmd.bij_set = 1'b1;
          cmd.cnt_inc = 1'b1;
          state_nxt = sts.cnt_at_end ? S_V_END : S_V_RD;
        end else begin
          cmd.seen_rd = 1'b1;
          state_nxt = S_V_S;
        end
      end
      S_V_S: begin
        if (sts.seen_hit) begin
          cmd.bij_set = 1'b1;
        end else begin
          cmd.seen_set = 1'b1;
        end
        cmd.cnt_inc = 1'b1;
        state_nxt = sts.cnt_at_end ? S_V_END : S_V_RD;
      end
      S_V_END: begin
        if (sts.bij_fail) begin
          cmd.cache_set = 1'b1;
          cmd.cache_code = ST_NOT_BIJ;
          state_nxt = S_Q_CHK;
        end else begin
          cmd.div_tc = 1'b1;
          state_nxt = S_V_TC;
        end
      end
      S_V_TC: begin
        if (sts.div_done) begin
          cmd.cache_set = 1'b1;
          cmd.cache_code = ST_OK;
          cmd.tc_load = 1'b1;
          state_nxt = S_Q_CHK;
        end
      end
      S_Q_CHK: begin
        if (sts.cached_status != ST_OK) begin
          if (sts.out_free) begin
            cmd.out_load = 1'b1;
            cmd.out_status = sts.cached_status;
            state_nxt = S_IDLE;
          end
        end else if (sts.q_oor) begin
          if (sts.out_free) begin
            cmd.out_load = 1'b1;
            cmd.out_status = ST_RANGE;
            state_nxt = S_IDLE;
          end
        end else begin
          cmd.tbl_rd_q = 1'b1;
          state_nxt = S_Q_RD;
        end
      end
      S_Q_RD: begin
        cmd.div_q = 1'b1;
        state_nxt = S_Q_DIV;
      end
      S_Q_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_Q_FIN;
        end
      end
      S_Q_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_query = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free) else $error("result overwritten");
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_tc || cmd.div_q) |-> !sts.div_busy) else $error("divider restarted");
  a_cache_code: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cache_set |-> cmd.cache_code != ST_RANGE) else $error("bad cached status");
  a_ok_has_tc: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.cache_set && cmd.cache_code == ST_OK) |-> cmd.tc_load)
    else $error("ok cached without tile count");
endmodule

// ----- design/embedding_tile_locator.sv -----
// A write item goes through S_WR_FIN to the result register; a cached query
// goes through S_Q_CHK, S_Q_RD, S_Q_DIV (13-step divider) and S_Q_FIN; an
// uncached query first runs the checks, the seen bitmap clear, the walk over
// the dimensions and the tile count divide. One item at a time: a new item
// is taken only in S_IDLE. Reset: synchronous active-low rst_n, then a pass
// clears the table written flags while no item is accepted.
// Depends on etl_pkg, etl_if, etl_ctrl, etl_dp.
`timescale 1ns / 1ps
module embedding_tile_locator import etl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  etl_in_if.sink                in_ch,
  etl_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);
  cmd_t cmd;
  sts_t sts;

  // sequencer: owns the handshake and the walk order
  etl_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_opcode(in_ch.opcode), .in_ready(in_ch.ready),
    .sts(sts), .cmd(cmd)
  );

  // storage, checks, divider and the result register
  etl_dp u_dp (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_logical(in_ch.logical_index), .in_physical(in_ch.physical_index),
    .cmd(cmd), .sts(sts),
    .out_ready(out_ch.ready), .out_valid(out_ch.valid),
    .out_status(out_ch.status), .out_tile(out_ch.tile_no),
    .out_texel(out_ch.texel_no), .out_lane(out_ch.lane_index),
    .out_tcount(out_ch.tile_count)
  );
endmodule
